// ===== rtl/core/isr_pkg.sv =====
// Package for the indexed stack core: widths, operation codes, command word,
// back-end state type and status codes. No dependencies.
`default_nettype none

package isr_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int ENTRY_WIDTH_DEFAULT = 64;

    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH           = 3'd0,
        OP_POP            = 3'd1,
        OP_READ           = 3'd2,
        OP_DUP            = 3'd3,
        OP_REMOVE_RET     = 3'd4,
        OP_REMOVE_DISCARD = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_READ,
        K_DUP,
        K_REMOVE,
        K_NOP
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FETCH,
        BS_SHIFT
    } t_bstate;

    typedef struct packed {
        t_kind                kind;
        logic                 ret;
        logic [POS_W-1:0]     position;
        logic [PAYLOAD_W-1:0] entry;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic full;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== rtl/core/isr_ifs.sv =====
// Valid/ready channel interfaces for the indexed stack core.
// Depends on isr_pkg for field widths.
`default_nettype none

interface isr_in_if;
    import isr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     position;
    logic [PAYLOAD_W-1:0] push_entry;

    modport source (output valid, output op, output position, output push_entry,
                    input ready);
    modport sink   (input valid, input op, input position, input push_entry,
                    output ready);
endinterface

interface isr_out_if;
    import isr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] entry_out;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, output status, output entry_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input entry_out, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/indexed_stack_with_removal_core.sv =====
// Indexed stack core. Words pass a front-end queue, a sequencer and the output
// register. Pop, read, duplicate and remove add a fetch state; remove adds a
// shift per entry above it (up to DEPTH - 1) on the single memory port pair.
// One push per cycle while results are taken, none during a fetch or shift.
// Reset clears the count, queue and output valid; the memory is not cleared.
`default_nettype none

module indexed_stack_with_removal_core #(
    parameter int DEPTH       = isr_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = isr_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isr_in_if.sink    i_in,
    isr_out_if.source o_out
);
    import isr_pkg::*;

    logic       cmd_valid;
    logic       cmd_ready;
    t_cmd       cmd;
    t_back_stat stat;

    isr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    isr_back #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_out       (o_out),
        .o_stat      (stat)
    );

    // a pending result means the sequencer has nothing in flight
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> stat.idle)
        else $error("result pending while back end busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL) |-> stat.full)
        else $error("full status with room in the stack");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_RANGE) |-> (o_out.entry_out == '0))
        else $error("range error carries a nonzero word");

endmodule

`default_nettype wire

// ===== rtl/core/isr_front.sv =====
// Front end: accepts input words, decodes the operation code into a command
// and holds it in a two-entry queue for the back end. Depends on isr_pkg, isr_ifs.
`default_nettype none

module isr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isr_in_if.sink        i_in,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output isr_pkg::t_cmd o_cmd
);
    import isr_pkg::*;

    t_cmd       n_cmd;
    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_fill;
    logic       push;
    logic       pop;

    always_comb begin
        n_cmd.position = i_in.position;
        n_cmd.entry    = i_in.push_entry;
        n_cmd.ret      = 1'b0;
        unique case (t_op'(i_in.op))
            OP_PUSH:           n_cmd.kind = K_PUSH;
            OP_POP:            n_cmd.kind = K_POP;
            OP_READ:           n_cmd.kind = K_READ;
            OP_DUP:            n_cmd.kind = K_DUP;
            OP_REMOVE_RET: begin
                n_cmd.kind = K_REMOVE;
                n_cmd.ret  = 1'b1;
            end
            OP_REMOVE_DISCARD: n_cmd.kind = K_REMOVE;
            default:           n_cmd.kind = K_NOP;
        endcase
    end

    assign i_in.ready  = (r_fill != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/isr_back.sv =====
// Back end: stack memory, fill count and the sequencer that carries out each
// command, plus the output register. Depends on isr_pkg, isr_ifs.
`default_nettype none

module isr_back #(
    parameter int DEPTH       = isr_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = isr_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  isr_pkg::t_cmd       i_cmd,
    isr_out_if.source           o_out,
    output isr_pkg::t_back_stat o_stat
);
    import isr_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [ENTRY_WIDTH-1:0] r_mem [DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rdata;

    t_bstate                r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_ptr, n_ptr;
    t_kind                  r_kind, n_kind;
    logic                   r_ret, n_ret;
    logic [ENTRY_WIDTH-1:0] r_res, n_res;

    logic                   mem_we;
    logic                   mem_re;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_raddr;
    logic [ENTRY_WIDTH-1:0] mem_wdata;

    logic                   emit;
    t_status                emit_status;
    logic [ENTRY_WIDTH-1:0] emit_entry;

    logic                   r_out_valid;
    t_status                r_out_status;
    logic [PAYLOAD_W-1:0]   r_out_entry;
    logic [COUNT_W-1:0]     r_out_count;

    logic                   slot_free;
    logic                   start;
    logic                   full;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        cnt_ext;
    logic [CMPW-1:0]        diff;
    logic                   pos_ok;
    logic [AW-1:0]          idx;
    logic                   more1;
    logic                   more2;

    assign slot_free = !r_out_valid || o_out.ready;
    assign start     = (r_state == BS_IDLE) && i_cmd_valid && slot_free;
    assign full      = (r_count == CW'(DEPTH));
    assign pos_ext   = CMPW'(i_cmd.position);
    assign cnt_ext   = CMPW'(r_count);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign diff      = cnt_ext - pos_ext;
    assign idx       = diff[AW-1:0];
    // entries remain above the slot being refilled
    assign more1     = ((CW+1)'(r_ptr) + (CW+1)'(1)) < (CW+1)'(r_count);
    assign more2     = ((CW+1)'(r_ptr) + (CW+1)'(2)) < (CW+1)'(r_count);

    assign o_cmd_ready = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_kind <= n_kind;
        r_ret  <= n_ret;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_kind      = r_kind;
        n_ret       = r_ret;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = AW'(r_count);
        mem_raddr   = r_ptr;
        mem_wdata   = r_rdata;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_entry  = '0;

        unique case (r_state)
            BS_IDLE: begin
                if (start) begin
                    n_kind = i_cmd.kind;
                    n_ret  = i_cmd.ret;
                    case (i_cmd.kind)
                        K_PUSH: begin
                            emit = 1'b1;
                            if (full) begin
                                emit_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = i_cmd.entry[ENTRY_WIDTH-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        K_POP: begin
                            if (r_count == '0) begin
                                emit        = 1'b1;
                                emit_status = ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = AW'(r_count - CW'(1));
                                n_ptr     = AW'(r_count - CW'(1));
                                n_state   = BS_FETCH;
                            end
                        end
                        K_READ, K_DUP, K_REMOVE: begin
                            if (!pos_ok) begin
                                emit        = 1'b1;
                                emit_status = ST_RANGE;
                            end else if (i_cmd.kind == K_DUP && full) begin
                                emit        = 1'b1;
                                emit_status = ST_FULL;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = idx;
                                n_ptr     = idx;
                                n_state   = BS_FETCH;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            BS_FETCH: begin
                case (r_kind)
                    K_POP: begin
                        emit       = 1'b1;
                        emit_entry = r_rdata;
                        n_count    = r_count - CW'(1);
                        n_state    = BS_IDLE;
                    end
                    K_DUP: begin
                        mem_we  = 1'b1;
                        emit    = 1'b1;
                        n_count = r_count + CW'(1);
                        n_state = BS_IDLE;
                    end
                    K_REMOVE: begin
                        n_res = r_ret ? r_rdata : '0;
                        if (more1) begin
                            mem_re    = 1'b1;
                            mem_raddr = r_ptr + AW'(1);
                            n_state   = BS_SHIFT;
                        end else begin
                            emit       = 1'b1;
                            emit_entry = r_ret ? r_rdata : '0;
                            n_count    = r_count - CW'(1);
                            n_state    = BS_IDLE;
                        end
                    end
                    default: begin
                        emit       = 1'b1;
                        emit_entry = r_rdata;
                        n_state    = BS_IDLE;
                    end
                endcase
            end
            BS_SHIFT: begin
                // move the entry above down into the gap, fetch the next one
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                if (more2) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_ptr + AW'(2);
                    n_ptr     = r_ptr + AW'(1);
                end else begin
                    emit       = 1'b1;
                    emit_entry = r_res;
                    n_count    = r_count - CW'(1);
                    n_state    = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= emit_status;
            r_out_entry  <= PAYLOAD_W'(emit_entry);
            r_out_count  <= COUNT_W'(n_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.entry_out   = r_out_entry;
    assign o_out.entry_count = r_out_count;

    assign o_stat.idle = (r_state == BS_IDLE);
    assign o_stat.full = full;

endmodule

`default_nettype wire

// ===== bench/indexed_stack_with_removal_core_test.sv =====
`timescale 1ns / 100ps
// Testbench for indexed_stack_with_removal_core: directed and random stack traffic
// with a result scoreboard. Depends on isr_pkg, isr_ifs and the core RTL.

module indexed_stack_with_removal_core_test;
    import isr_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 217;
    localparam int REPORT_MAX   = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIX} t_run_mode;

    // Shadow stack: predicts one result word per accepted command word.
    class stack_scoreboard;
        typedef struct {
            logic [STATUS_W-1:0]  st;
            logic [PAYLOAD_W-1:0] entry;
            logic [COUNT_W-1:0]   count;
        } t_expected;

        logic [PAYLOAD_W-1:0] held [DEPTH_DEFAULT];
        int unsigned          fill;
        t_expected            expected_q[$];
        int                   errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned depth();
            return fill;
        endfunction

        function int unsigned waiting();
            return expected_q.size();
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [PAYLOAD_W-1:0] val);
            t_expected   want;
            int unsigned idx;
            logic        pos_ok;

            want.st    = ST_OK;
            want.entry = '0;
            pos_ok     = (pos >= 1) && (pos <= fill);
            idx        = fill - pos;
            case (op)
                OP_PUSH: begin
                    if (fill >= DEPTH_DEFAULT) begin
                        want.st = ST_FULL;
                    end else begin
                        held[fill] = val;
                        fill++;
                    end
                end
                OP_POP: begin
                    if (fill == 0) begin
                        want.st = ST_RANGE;
                    end else begin
                        fill--;
                        want.entry = held[fill];
                    end
                end
                OP_READ: begin
                    if (!pos_ok) want.st = ST_RANGE;
                    else want.entry = held[idx];
                end
                OP_DUP: begin
                    // range check wins over the full check
                    if (!pos_ok) begin
                        want.st = ST_RANGE;
                    end else if (fill >= DEPTH_DEFAULT) begin
                        want.st = ST_FULL;
                    end else begin
                        held[fill] = held[idx];
                        fill++;
                    end
                end
                OP_REMOVE_RET, OP_REMOVE_DISCARD: begin
                    if (!pos_ok) begin
                        want.st = ST_RANGE;
                    end else begin
                        if (op == OP_REMOVE_RET) want.entry = held[idx];
                        // close the gap: entries above move down by one
                        for (int unsigned i = idx; i + 1 < fill; i++) held[i] = held[i + 1];
                        fill--;
                    end
                end
                default: ;
            endcase
            want.count = fill[COUNT_W-1:0];
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [PAYLOAD_W-1:0] entry,
                                   logic [COUNT_W-1:0] count);
            t_expected want;

            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result word: status %0d entry %h count %0d",
                             st, entry, count);
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.st || entry !== want.entry || count !== want.count) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display({"mismatch: expected status %0d entry %h count %0d, ",
                              "got status %0d entry %h count %0d"},
                             want.st, want.entry, want.count, st, entry, count);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   tx_idle_pct;
    int   rx_idle_pct;

    stack_scoreboard sb;

    isr_in_if  in_ch ();
    isr_out_if out_ch ();

    indexed_stack_with_removal_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check every accepted word, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.status, out_ch.entry_out, out_ch.entry_count);
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Called right after a rising edge; returns at the edge that accepts the word.
    task automatic send_word(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [PAYLOAD_W-1:0] val);
        int gap;

        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.position   <= pos;
        in_ch.push_entry <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, pos, val);
    endtask

    task automatic send_random(t_run_mode mode);
        t_op                  op_order[6];
        int unsigned          cut[6];
        int unsigned          fill;
        int unsigned          r;
        logic [OP_W-1:0]      op;
        logic [POS_W-1:0]     pos;
        logic [PAYLOAD_W-1:0] val;

        op_order = '{OP_PUSH, OP_DUP, OP_READ, OP_POP, OP_REMOVE_RET, OP_REMOVE_DISCARD};
        case (mode)
            RUN_FILL:  cut = '{55, 75, 82, 88, 93, 97};
            RUN_DRAIN: cut = '{15, 20, 35, 60, 78, 96};
            default:   cut = '{30, 40, 55, 70, 82, 96};
        endcase
        fill = sb.depth();
        r    = $urandom_range(99);
        op   = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        for (int i = 5; i >= 0; i--) if (r < cut[i]) op = op_order[i];

        r = $urandom_range(99);
        if (op == OP_PUSH || op == OP_POP || op >= OP_UNUSED_LO) begin
            pos = POS_W'($urandom_range(127));
        end else if (fill == 0 || r < 12) begin
            pos = ($urandom_range(3) == 0) ? '0 : POS_W'($urandom_range(127, fill + 1));
        end else if (r < 22) begin
            pos = 7'd1;
        end else if (r < 32) begin
            pos = POS_W'(fill);
        end else begin
            pos = POS_W'($urandom_range(fill, 1));
        end

        r = $urandom_range(9);
        if (r == 0) val = '0;
        else if (r == 1) val = '1;
        else val = {$urandom, $urandom};
        send_word(op, pos, val);
    endtask

    initial begin
        int        sent;
        int        len;
        t_run_mode mode;

        sb               = new();
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_PUSH;
        in_ch.position   = '0;
        in_ch.push_entry = '0;
        out_ch.ready     = 1'b0;
        tx_idle_pct      = 15;
        rx_idle_pct      = 66;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty errors, unused codes, bad positions, bottom and top access.
        send_word(OP_POP, 7'd0, '0);
        send_word(OP_READ, 7'd1, '0);
        send_word(OP_UNUSED_LO, 7'd0, '1);
        send_word(OP_UNUSED_HI, 7'd127, '0);
        send_word(OP_PUSH, 7'd0, '1);
        send_word(OP_PUSH, 7'd127, '0);
        send_word(OP_PUSH, 7'd0, {32{2'b01}});
        send_word(OP_READ, 7'd0, '0);
        send_word(OP_READ, 7'd4, '0);
        send_word(OP_READ, 7'd127, '0);
        send_word(OP_READ, 7'd3, '0);
        send_word(OP_DUP, 7'd3, '0);
        send_word(OP_DUP, 7'd0, '0);
        send_word(OP_REMOVE_RET, 7'd4, '0);
        send_word(OP_REMOVE_DISCARD, 7'd9, '0);
        send_word(OP_REMOVE_DISCARD, 7'd1, '0);
        send_word(OP_REMOVE_RET, 7'd2, '0);
        send_word(OP_POP, 7'd0, '0);
        send_word(OP_POP, 7'd0, '0);
        send_word(OP_DUP, 7'd1, '0);
        send_word(OP_REMOVE_RET, 7'd1, '0);

        // Random: each phase opens with a run long enough to fill the stack.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 15; rx_idle_pct = 66; end
                1: begin tx_idle_pct = 66; rx_idle_pct = 15; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int i = 0; i < 110; i++) send_random(RUN_FILL);
            sent = 110;
            while (sent < PHASE_ITEMS) begin
                mode = t_run_mode'($urandom_range(2));
                len  = $urandom_range(60, 20);
                for (int i = 0; i < len; i++) send_random(mode);
                sent += len;
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== indexed_stack_with_removal_core.f =====
rtl/core/isr_pkg.sv
rtl/core/isr_ifs.sv
rtl/core/isr_front.sv
rtl/core/isr_back.sv
rtl/core/indexed_stack_with_removal_core.sv
bench/indexed_stack_with_removal_core_test.sv
